FILE: rtl/swlpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swlpe_pkg
// Shared types and constants for the sorted word list prefix encoder.
// ----------------------------------------------------------------------------
package swlpe_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned StoreDepth = 256;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  typedef logic [AddrW-1:0] addr_t;

  localparam byte_t MaxWordLen = 8'd254;
  localparam byte_t SepMax     = 8'd32;
  localparam byte_t EscLimit   = 8'd31;
  localparam byte_t EscCode    = 8'd0;

  localparam int unsigned MaxCodes = 3;

  typedef logic [$clog2(MaxCodes+1)-1:0] cnt_t;

endpackage : swlpe_pkg
`default_nettype wire

FILE: rtl/sorted_word_list_prefix_encoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_word_list_prefix_encoder_unit
// Front-codes a sorted word list: emits shared prefix length plus one
// (escaped by a zero byte above 31), then the remaining word bytes.
// ----------------------------------------------------------------------------
//  channel   dir  payload                         handshake
//  s_axis    in   tdata[7:0] text_byte            tvalid/tready
//  m_axis    out  tdata[7:0] code_byte,           tvalid/tready
//                 tlast last_of_run
//
//  the word store read and write happen on the accept edge, the compare
//  follows from the registered read in the match stage. bytes that cause
//  one or no code sustain one transfer per cycle while the output is ready;
//  a byte causing several codes stalls the next byte until they are taken.
//  reset clears control state only; the word store needs no clearing.
//  output back-pressure stalls the match stage and then the input.
// ----------------------------------------------------------------------------
module sorted_word_list_prefix_encoder_unit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire  swlpe_pkg::byte_t s_axis_tdata_i,  // [7:0] text_byte
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  output swlpe_pkg::byte_t     m_axis_tdata_o,    // [7:0] code_byte
  output logic                 m_axis_tlast_o     // last_of_run
);
  import swlpe_pkg::*;

  // word store
  byte_t mem [StoreDepth];
  byte_t rd_q;

  // front-end word tracking
  byte_t pos_q, prev_len_q;
  logic  in_word_q;

  // match stage
  logic  s2_v_q, s2_sep_q, s2_start_q, s2_cut_q, s2_lt_q;
  byte_t s2_b_q, s2_p_q;
  logic  sm_q, sm_d;

  // output buffer
  byte_t ob_code_q [MaxCodes];
  cnt_t  ob_rem_q, ob_idx_q;

  byte_t codes [MaxCodes];
  cnt_t  n_codes;

  logic  in_xfer, is_sep, s2_load, s2_go, ob_free;
  byte_t p1, np1;
  logic  lt1, cut1;

  assign is_sep  = s_axis_tdata_i <= SepMax;
  assign p1      = in_word_q ? pos_q : '0;
  assign lt1     = p1 < prev_len_q;
  assign np1     = p1 + 8'd1;
  assign cut1    = np1 >= MaxWordLen;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign s2_load = in_xfer && (!is_sep || in_word_q);

  assign ob_free = (ob_rem_q == cnt_t'(0)) || ((ob_rem_q == cnt_t'(1)) && m_axis_tready_i);
  assign s2_go   = s2_v_q && ob_free;
  assign s_axis_tready_o = !s2_v_q || s2_go;

  assign m_axis_tvalid_o = ob_rem_q != cnt_t'(0);
  assign m_axis_tdata_o  = ob_code_q[ob_idx_q[1:0]];
  assign m_axis_tlast_o  = ob_rem_q == cnt_t'(1);

  always_ff @(posedge clk_i) begin
    if (in_xfer && !is_sep) begin
      rd_q           <= mem[addr_t'(p1)];
      mem[addr_t'(p1)] <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      prev_len_q <= '0;
      in_word_q  <= 1'b0;
    end else if (in_xfer) begin
      if (is_sep) begin
        if (in_word_q) begin
          prev_len_q <= pos_q;
          pos_q      <= '0;
          in_word_q  <= 1'b0;
        end
      end else if (cut1) begin
        prev_len_q <= np1;
        pos_q      <= '0;
        in_word_q  <= 1'b0;
      end else begin
        pos_q     <= np1;
        in_word_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (!s2_v_q || s2_go) begin
      s2_v_q <= s2_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_sep_q   <= is_sep;
      s2_start_q <= !in_word_q;
      s2_cut_q   <= cut1;
      s2_lt_q    <= lt1;
      s2_b_q     <= s_axis_tdata_i;
      s2_p_q     <= is_sep ? pos_q : p1;
    end
  end

  // code list for the item in the match stage
  always_comb begin
    logic  m_eff, m_after, hit;
    byte_t pre, pre2;
    m_eff   = s2_start_q ? 1'b1 : sm_q;
    hit     = s2_lt_q && (rd_q == s2_b_q);
    pre     = s2_p_q + 8'd1;
    pre2    = s2_p_q + 8'd2;
    m_after = m_eff;
    n_codes = '0;
    for (int i = 0; i < MaxCodes; i++) codes[i] = '0;
    if (s2_sep_q) begin
      if (m_eff) begin
        if (s2_p_q > EscLimit) begin
          codes[n_codes[1:0]] = EscCode;
          n_codes = n_codes + cnt_t'(1);
        end
        codes[n_codes[1:0]] = pre;
        n_codes = n_codes + cnt_t'(1);
      end
      m_after = 1'b1;
    end else begin
      if (m_eff && !hit) begin
        if (s2_p_q > EscLimit) begin
          codes[n_codes[1:0]] = EscCode;
          n_codes = n_codes + cnt_t'(1);
        end
        codes[n_codes[1:0]] = pre;
        n_codes = n_codes + cnt_t'(1);
        codes[n_codes[1:0]] = s2_b_q;
        n_codes = n_codes + cnt_t'(1);
        m_after = 1'b0;
      end else if (!m_eff) begin
        codes[n_codes[1:0]] = s2_b_q;
        n_codes = n_codes + cnt_t'(1);
      end
      if (s2_cut_q) begin
        if (m_after) begin
          if (pre > EscLimit) begin
            codes[n_codes[1:0]] = EscCode;
            n_codes = n_codes + cnt_t'(1);
          end
          codes[n_codes[1:0]] = pre2;
          n_codes = n_codes + cnt_t'(1);
        end
        m_after = 1'b1;
      end
    end
    sm_d = m_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_q     <= 1'b1;
      ob_rem_q <= '0;
      ob_idx_q <= '0;
    end else if (s2_go) begin
      sm_q     <= sm_d;
      ob_rem_q <= n_codes;
      ob_idx_q <= '0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      ob_rem_q <= ob_rem_q - cnt_t'(1);
      ob_idx_q <= ob_idx_q + cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      for (int i = 0; i < MaxCodes; i++) ob_code_q[i] <= codes[i];
    end
  end

endmodule : sorted_word_list_prefix_encoder_unit
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted word list prefix encoder. Drives a text
// stream of separators and words with shared prefixes (directed corner words,
// then random word lists mixed with noise) and checks every code byte and its
// run marker against a front-coding predictor kept alongside the block.
// ----------------------------------------------------------------------------
module tb;
  import swlpe_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 120;
  localparam int RandomItems   = 20;
  localparam int DrainCycles   = 20;

  typedef struct packed {
    byte_t code;
    logic  last;
  } code_rec_t;

  class front_code_checker;
    byte_t     word_mem [StoreDepth];
    byte_t     prev_len;
    byte_t     cur_pos;
    bit        matching;
    bit        in_word;
    code_rec_t expected_codes[$];
    int        errors;

    function new();
      prev_len = '0;
      cur_pos  = '0;
      matching = 1'b1;
      in_word  = 1'b0;
      errors   = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void add_prefix(ref byte_t codes[$], input byte_t pre);
      if (pre > EscLimit) codes.push_back(EscCode);
      codes.push_back(pre + 8'd1);
    endfunction

    function void close_word(ref byte_t codes[$]);
      if (matching) add_prefix(codes, cur_pos);
      prev_len = cur_pos;
      cur_pos  = '0;
      matching = 1'b1;
      in_word  = 1'b0;
    endfunction

    function void note_text_byte(byte_t b);
      byte_t     codes[$];
      byte_t     p;
      code_rec_t rec;
      if (b <= SepMax) begin
        if (in_word) close_word(codes);
      end else begin
        if (!in_word) begin
          in_word  = 1'b1;
          cur_pos  = '0;
          matching = 1'b1;
        end
        p = cur_pos;
        if (matching) begin
          if (!(p < prev_len && word_mem[p] == b)) begin
            add_prefix(codes, p);
            codes.push_back(b);
            matching = 1'b0;
          end
        end else begin
          codes.push_back(b);
        end
        word_mem[p] = b;
        cur_pos = p + 8'd1;
        if (cur_pos >= MaxWordLen) close_word(codes);
      end
      foreach (codes[i]) begin
        rec.code = codes[i];
        rec.last = (i == codes.size() - 1);
        expected_codes.push_back(rec);
      end
    endfunction

    task check_code(byte_t code, logic last);
      code_rec_t rec;
      if (expected_codes.size() == 0) begin
        report($sformatf("code 0x%02h last %0b with nothing expected", code, last));
      end else begin
        rec = expected_codes.pop_front();
        if (code !== rec.code)
          report($sformatf("code 0x%02h, expected 0x%02h", code, rec.code));
        if (last !== rec.last)
          report($sformatf("last %0b, expected %0b on code 0x%02h", last, rec.last, rec.code));
      end
    endtask
  endclass

  logic  clk_i;
  logic  rst_n;
  logic  s_valid;
  byte_t s_data;
  logic  rx_ready;
  wire   s_axis_tready_o;
  wire   m_axis_tvalid_o;
  byte_t m_axis_tdata_o;
  wire   m_axis_tlast_o;

  front_code_checker sb;
  byte_t text_q[$];
  byte_t last_word[$];
  int    tx_idle_pct;
  int    rx_idle_pct;
  bit    hold_req;
  int    hold_left;
  int    idle_cycles;

  sorted_word_list_prefix_encoder_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (rx_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic byte_t word_char();
    return byte_t'($urandom_range(33, 255));
  endfunction

  task automatic put_word(input byte_t w[$], input bit close);
    foreach (w[i]) text_q.push_back(w[i]);
    if (close) text_q.push_back(byte_t'($urandom_range(0, SepMax)));
    last_word = w;
  endtask

  task automatic build_text();
    byte_t w[$];
    byte_t full[$];
    int    n0;
    int    k;
    int    nsuf;
    // separators outside a word
    text_q.push_back(8'd0);
    text_q.push_back(SepMax);
    // a word cut at maximum length, then a separator outside any word
    repeat (MaxWordLen) full.push_back(word_char());
    put_word(full, 1);
    // departure after a prefix above the escape limit, then an end while matching
    w = full[0:32];
    w.push_back((full[33] == 8'hff) ? 8'h21 : full[33] + 8'd1);
    put_word(w, 1);
    void'(w.pop_back());
    put_word(w, 1);

    n0 = text_q.size();
    while (text_q.size() - n0 < RandomItems) begin
      if ($urandom_range(0, 99) < 85) begin
        k = $urandom_range(0, last_word.size());
        w.delete();
        for (int i = 0; i < k; i++) w.push_back(last_word[i]);
        nsuf = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if ($urandom_range(0, 19) == 0) nsuf = $urandom_range(30, 50);
        if (w.size() == 0 && nsuf == 0) nsuf = 1;
        while (w.size() > 150) void'(w.pop_back());
        repeat (nsuf) w.push_back(word_char());
        put_word(w, 1);
        if ($urandom_range(0, 4) == 0) text_q.push_back(byte_t'($urandom_range(0, SepMax)));
      end else begin
        repeat ($urandom_range(1, 8)) text_q.push_back(byte_t'($urandom_range(0, 255)));
      end
    end
    text_q.push_back(8'd0);
  endtask

  task automatic drive_text();
    int n;
    n = text_q.size();
    for (int idx = 0; idx < n; idx++) begin
      if (idx == n / 3) begin
        tx_idle_pct = 55;
        rx_idle_pct = 35;
      end else if (idx == 2 * n / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
      end
      while ($urandom_range(0, 99) < tx_idle_pct) begin
        s_valid <= 1'b0;
        @(negedge clk_i);
      end
      s_valid <= 1'b1;
      s_data  <= text_q[idx];
      do @(posedge clk_i); while (!s_axis_tready_o);
      @(negedge clk_i);
    end
    s_valid <= 1'b0;
  endtask

  // receiver side, with one long hold-off to back up the block
  initial begin
    rx_ready  = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        rx_ready <= 1'b0;
        hold_left--;
      end else begin
        rx_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (m_axis_tvalid_o && rx_ready) sb.check_code(m_axis_tdata_o, m_axis_tlast_o);
      if (s_valid && s_axis_tready_o) sb.note_text_byte(s_data);
      if ((m_axis_tvalid_o && rx_ready) || (s_valid && s_axis_tready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("sorted_word_list_prefix_encoder_unit test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    sb          = new();
    s_valid     = 1'b0;
    s_data      = '0;
    rst_n       = 1'b0;
    hold_req    = 1'b0;
    idle_cycles = 0;
    tx_idle_pct = 35;
    rx_idle_pct = 55;
    build_text();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);
    drive_text();
    while (sb.expected_codes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("sorted_word_list_prefix_encoder_unit test passed");
    end else begin
      $display("sorted_word_list_prefix_encoder_unit test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
